// ===== design/cfsf_pkg.sv =====
// ----------------------------------------------------------------------------
// cfsf_pkg
// Shared types, constants and the crc-8 step for the can frame serial framer.
// ----------------------------------------------------------------------------
package cfsf_pkg;

  localparam int unsigned IdentW    = 29;
  localparam int unsigned LenW      = 4;
  localparam int unsigned PayloadW  = 64;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned PosW      = 4;
  localparam int unsigned InDataW   = 104;
  localparam int unsigned DataIdxW  = 3;

  localparam logic [LenW-1:0]  MaxPayload = 4'd8;
  localparam logic [ByteW-1:0] StartByte  = 8'hAA;
  localparam logic [ByteW-1:0] CrcPoly    = 8'h07;

  // frame byte positions
  localparam logic [PosW-1:0] PosStart = 4'd0;
  localparam logic [PosW-1:0] PosFlag  = 4'd1;
  localparam logic [PosW-1:0] PosId3   = 4'd2;
  localparam logic [PosW-1:0] PosId2   = 4'd3;
  localparam logic [PosW-1:0] PosId1   = 4'd4;
  localparam logic [PosW-1:0] PosId0   = 4'd5;
  localparam logic [PosW-1:0] PosLen   = 4'd6;
  localparam logic [PosW-1:0] PosData0 = 4'd7;
  localparam logic [PosW-1:0] PosCrc   = 4'd15;

  typedef enum logic {
    StIdle,
    StSend
  } state_e;

  typedef struct packed {
    logic load;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic last;
  } stat_t;

  function automatic logic [ByteW-1:0] crc8_step(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int j = 0; j < 8; j++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== design/cfsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfsf_ctrl
// Frame sequencer: idle / send state machine driving the handshakes.
// ----------------------------------------------------------------------------
module cfsf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  input  cfsf_pkg::stat_t stat_i,
  output cfsf_pkg::cmd_t  cmd_o
);
  import cfsf_pkg::*;

  state_e state_q, state_d;
  logic   load;
  logic   advance;

  always_comb begin
    s_tready_o = (state_q == StIdle) || (stat_i.last && m_tready_i);
    m_tvalid_o = (state_q == StSend);
    load       = s_tvalid_i && s_tready_o;
    advance    = (state_q == StSend) && m_tready_i;
    cmd_o.load    = load;
    cmd_o.advance = advance;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (load) state_d = StSend;
      end
      StSend: begin
        if (advance && stat_i.last && !load) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/cfsf_dpath.sv =====
// ----------------------------------------------------------------------------
// cfsf_dpath
// Message hold registers, byte position counter, byte select and crc-8.
// ----------------------------------------------------------------------------
module cfsf_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cfsf_pkg::cmd_t                  cmd_i,
  output cfsf_pkg::stat_t                 stat_o,
  input  logic                            extended_i,
  input  logic [cfsf_pkg::IdentW-1:0]     ident_i,
  input  logic [cfsf_pkg::LenW-1:0]       payload_len_i,
  input  logic [cfsf_pkg::PayloadW-1:0]   payload_i,
  output logic [cfsf_pkg::ByteW-1:0]      frame_byte_o,
  output logic                            last_byte_o
);
  import cfsf_pkg::*;

  logic [PayloadW-1:0] payload_q;
  logic [IdentW-1:0]   ident_q;
  logic [LenW-1:0]     len_q;
  logic                ext_q;
  logic [ByteW-1:0]    crc_q, crc_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [LenW-1:0]     len_sat;
  logic [DataIdxW-1:0] data_idx;
  logic [ByteW-1:0]    byte_sel;

  assign len_sat  = (payload_len_i > MaxPayload) ? MaxPayload : payload_len_i;
  assign data_idx = DataIdxW'(pos_q - PosData0);

  always_comb begin
    unique case (pos_q)
      PosStart: byte_sel = StartByte;
      PosFlag:  byte_sel = {{(ByteW-1){1'b0}}, ext_q};
      PosId3:   byte_sel = {3'b000, ident_q[28:24]};
      PosId2:   byte_sel = ident_q[23:16];
      PosId1:   byte_sel = ident_q[15:8];
      PosId0:   byte_sel = ident_q[7:0];
      PosLen:   byte_sel = {{(ByteW-LenW){1'b0}}, len_q};
      PosCrc:   byte_sel = crc_q;
      default: begin
        if ({1'b0, data_idx} < len_q) begin
          byte_sel = payload_q[data_idx*ByteW +: ByteW];
        end else begin
          byte_sel = '0;
        end
      end
    endcase
  end

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    if (cmd_i.load) begin
      pos_d = PosStart;
      crc_d = '0;
    end else if (cmd_i.advance) begin
      pos_d = pos_q + 1'b1;
      if (pos_q != PosStart && pos_q != PosCrc) begin
        crc_d = crc8_step(crc_q, byte_sel);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= '0;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_q <= '0;
      ident_q   <= '0;
      len_q     <= '0;
      ext_q     <= 1'b0;
    end else if (cmd_i.load) begin
      payload_q <= payload_i;
      ident_q   <= ident_i;
      len_q     <= len_sat;
      ext_q     <= extended_i;
    end
  end

  assign stat_o.last  = (pos_q == PosCrc);
  assign frame_byte_o = byte_sel;
  assign last_byte_o  = (pos_q == PosCrc);

endmodule

// ===== design/can_frame_serial_framer_crc8.sv =====
// ----------------------------------------------------------------------------
// can_frame_serial_framer_crc8
// Turns one can message into a 16-byte serial frame closed by a crc-8.
// ----------------------------------------------------------------------------
// start: the first frame byte is offered in the cycle after the message beat
// rate: one frame byte per cycle while the receiver is ready; the next message
//   is taken with the last beat
// reset: asynchronous, returns the sequencer to idle, no frame pending
// ----------------------------------------------------------------------------
module can_frame_serial_framer_crc8 (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // ident [28:0], payload_len [32:29], payload [96:33], zero pad [103:97]
  input  logic [cfsf_pkg::InDataW-1:0]   s_axis_tdata_i,
  // extended [0]
  input  logic [0:0]                     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // frame_byte [7:0]
  output logic [cfsf_pkg::ByteW-1:0]     m_axis_tdata_o,
  output logic                           m_axis_tlast_o
);
  import cfsf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cfsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cfsf_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .extended_i    (s_axis_tuser_i[0]),
    .ident_i       (s_axis_tdata_i[IdentW-1:0]),
    .payload_len_i (s_axis_tdata_i[IdentW+LenW-1:IdentW]),
    .payload_i     (s_axis_tdata_i[IdentW+LenW+PayloadW-1:IdentW+LenW]),
    .frame_byte_o  (m_axis_tdata_o),
    .last_byte_o   (m_axis_tlast_o)
  );

endmodule

// ===== design/cfsf_chk.sv =====
// ----------------------------------------------------------------------------
// cfsf_chk
// Port-level checks on the framer, bound to the top level.
// ----------------------------------------------------------------------------
module cfsf_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic [cfsf_pkg::InDataW-1:0] s_axis_tdata_i,
  input logic [0:0]                   s_axis_tuser_i,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [cfsf_pkg::ByteW-1:0]   m_axis_tdata_o,
  input logic                         m_axis_tlast_o
);
  import cfsf_pkg::*;

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output beat changed while stalled");

  // every message opens with the start byte
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=>
      m_axis_tvalid_o && m_axis_tdata_o == StartByte && !m_axis_tlast_o)
    else $error("frame does not open with start byte");

  // no new message mid-frame
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("input taken in the middle of a frame");

  // after the last beat with no new message the output goes quiet
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o &&
      !(s_axis_tvalid_i && s_axis_tready_o) |=> !m_axis_tvalid_o)
    else $error("output beat with no message pending");

endmodule

bind can_frame_serial_framer_crc8 cfsf_chk u_cfsf_chk (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the can frame serial framer with crc-8. Messages go
// in on the slave stream, and every one is expanded locally into its sixteen
// expected frame bytes. Each output beat is checked against the oldest
// expected byte, with random idling on both sides and a long receiver
// hold-off.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import cfsf_pkg::*;

  localparam int unsigned FrameBytes    = 16;
  localparam int unsigned IdleChance    = 26;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned MaxReports    = 30;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } frame_beat_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic [0:0]          s_axis_tuser_i  = '0;
  logic                m_axis_tready_i = 1'b0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [ByteW-1:0]    m_axis_tdata_o;
  logic                m_axis_tlast_o;

  frame_beat_t frame_beat_q[$];
  int unsigned error_count     = 0;
  int unsigned msg_count       = 0;
  int unsigned beat_count      = 0;
  int unsigned saturated_count = 0;
  int unsigned extended_count  = 0;
  int unsigned stall_cycles    = 0;
  bit          tx_idle_on      = 1'b0;
  bit          rx_idle_on      = 1'b0;
  int unsigned rx_hold_req     = 0;
  int unsigned rx_hold_left    = 0;

  always #10 clk_i = ~clk_i;

  can_frame_serial_framer_crc8 u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  function automatic logic [ByteW-1:0] crc8_next(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    r = crc ^ b;
    repeat (8) begin
      r = r[ByteW-1] ? ((r << 1) ^ CrcPoly) : (r << 1);
    end
    return r;
  endfunction

  function automatic void predict_can_frame(input logic             ext,
                                            input logic [IdentW-1:0] ident,
                                            input logic [LenW-1:0]   len_in,
                                            input logic [PayloadW-1:0] payload);
    logic [ByteW-1:0] frame [FrameBytes];
    logic [LenW-1:0]  len;
    logic [ByteW-1:0] crc;
    logic [31:0]      id32;
    frame_beat_t      beat;
    len  = (len_in > MaxPayload) ? MaxPayload : len_in;
    id32 = {3'b000, ident};
    if (len_in > MaxPayload) saturated_count++;
    if (ext) extended_count++;
    frame[PosStart] = StartByte;
    frame[PosFlag]  = {7'b0, ext};
    frame[PosId3]   = id32[31:24];
    frame[PosId2]   = id32[23:16];
    frame[PosId1]   = id32[15:8];
    frame[PosId0]   = id32[7:0];
    frame[PosLen]   = {4'b0, len};
    for (int k = 0; k < 8; k++) begin
      frame[PosData0 + k] = (k < len) ? payload[8*k +: 8] : '0;
    end
    crc = '0;
    for (int p = PosFlag; p < PosCrc; p++) begin
      crc = crc8_next(crc, frame[p]);
    end
    frame[PosCrc] = crc;
    for (int p = 0; p < FrameBytes; p++) begin
      beat.data = frame[p];
      beat.last = (p == PosCrc);
      frame_beat_q.push_back(beat);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [ByteW-1:0] exp_val,
                                 input logic [ByteW-1:0] got_val);
    if (error_count < MaxReports) begin
      $display("%0t mismatch on %s: expected %02h, got %02h (beat %0d)",
               $realtime, what, exp_val, got_val, beat_count);
    end
    error_count++;
  endtask

  // input capture, output check and watchdog
  always @(posedge clk_i) begin
    frame_beat_t exp_beat;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_can_frame(s_axis_tuser_i[0], s_axis_tdata_i[IdentW-1:0],
                          s_axis_tdata_i[IdentW +: LenW],
                          s_axis_tdata_i[IdentW+LenW +: PayloadW]);
        msg_count++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (frame_beat_q.size() == 0) begin
          report_mismatch("beat with no frame pending", '0, m_axis_tdata_o);
        end else begin
          exp_beat = frame_beat_q.pop_front();
          if (m_axis_tdata_o !== exp_beat.data) begin
            report_mismatch("frame byte", exp_beat.data, m_axis_tdata_o);
          end
          if (m_axis_tlast_o !== exp_beat.last) begin
            report_mismatch("tlast", {7'b0, exp_beat.last}, {7'b0, m_axis_tlast_o});
          end
        end
        beat_count++;
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("timeout: no beat for %0d cycles", StallLimit);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver ready with random idling and a counted hold-off
  always @(posedge clk_i) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (rx_idle_on) begin
      m_axis_tready_i <= ($urandom_range(99) >= IdleChance);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  task automatic send_message(input logic ext, input logic [IdentW-1:0] ident,
                              input logic [LenW-1:0] len,
                              input logic [PayloadW-1:0] payload);
    while (tx_idle_on && $urandom_range(99) < IdleChance) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= InDataW'({payload, len, ident});
    s_axis_tuser_i  <= ext;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic send_random_message();
    logic                ext;
    logic [IdentW-1:0]   ident;
    logic [LenW-1:0]     len;
    ext   = 1'($urandom_range(1));
    ident = ext ? IdentW'($urandom) : IdentW'($urandom_range(2047));
    len   = ($urandom_range(3) == 0) ? LenW'($urandom_range(15)) : LenW'($urandom_range(8));
    send_message(ext, ident, len, {$urandom, $urandom});
  endtask

  task automatic finish_burst();
    s_axis_tvalid_i <= 1'b0;
    while (frame_beat_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_field_extremes();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_message(1'b0, '0, '0, '0);
    send_message(1'b1, '1, MaxPayload, '1);
    send_message(1'b1, 29'h1F00_0000, 4'd3, 64'h0000_0000_00C3_B2A1);
    send_message(1'b0, 29'h00FF_FFFF, 4'd15, 64'h0123_4567_89AB_CDEF);
    finish_burst();
  endtask

  // every length, including the saturated ones and unused payload bytes
  task automatic test_length_sweep();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int l = 0; l < 16; l++) begin
      send_message(l[0], IdentW'(32'h1234_5678 + l), LenW'(l), 64'hF7E6_D5C4_B3A2_9180);
    end
    finish_burst();
  endtask

  task automatic test_back_to_back();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (60) send_random_message();
    finish_burst();
  endtask

  task automatic test_backpressure();
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b1;
    rx_hold_req = HoldOffCycles;
    repeat (6) send_random_message();
    finish_burst();
  endtask

  task automatic test_random_traffic();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (220) send_random_message();
    finish_burst();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_length_sweep();
    test_back_to_back();
    test_backpressure();
    test_random_traffic();
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d messages (%0d extended, %0d with saturated length), %0d bytes",
             msg_count, extended_count, saturated_count, beat_count);
    $display("with idling on both sides and a %0d-cycle receiver hold-off", HoldOffCycles);
    if (error_count == 0 && frame_beat_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/cfsf_pkg.sv
design/cfsf_ctrl.sv
design/cfsf_dpath.sv
design/can_frame_serial_framer_crc8.sv
design/cfsf_chk.sv
tb/testbench.sv
